>>> src/counting_semaphore_bank_macros.svh
// Assertion macros shared by the semaphore bank RTL.
`ifndef COUNTING_SEMAPHORE_BANK_MACROS_SVH
`define COUNTING_SEMAPHORE_BANK_MACROS_SVH

`ifndef SYNTHESIS

`define CSB_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("semaphore bank check failed");

`define CSB_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("semaphore bank check failed");

`define CSB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("semaphore bank check failed");

`else

`define CSB_ASSERT_ALWAYS(lbl, expr)
`define CSB_ASSERT_IMPLY(lbl, ante, cons)
`define CSB_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> src/csb_pkg.sv
// Constants and types of the counting semaphore bank.
`default_nettype none

package csb_pkg;

  localparam int NUM_SEMS     = 16;
  localparam int TASK_ID_BITS = 6;
  localparam int QUEUE_DEPTH  = 64;

  localparam int SLOT_W    = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int QPTR_W    = $clog2(QUEUE_DEPTH);
  localparam int MEM_AW    = SLOT_W + QPTR_W;
  localparam int MEM_DEPTH = 1 << MEM_AW;

  // Field widths of the words on the stream ports.
  localparam int ACTION_W  = 2;
  localparam int SEM_W     = 4;
  localparam int INIT_W    = 15;
  localparam int TASK_W    = 6;
  localparam int STATUS_W  = 3;
  localparam int CREATED_W = 5;
  localparam int WAKE_W    = 6;
  localparam int COUNT_W   = 16;
  localparam int DATA_W    = 32;

  localparam logic signed [COUNT_W-1:0] COUNT_MAX   = COUNT_W'(32767);
  localparam logic signed [COUNT_W-1:0] QFULL_COUNT = COUNT_W'(-QUEUE_DEPTH);
  localparam logic [CREATED_W-1:0]      NO_SLOT     = CREATED_W'(NUM_SEMS);

  typedef enum logic [ACTION_W-1:0] {
    ACT_CREATE = 2'd0,
    ACT_CLOSE  = 2'd1,
    ACT_WAIT   = 2'd2,
    ACT_SIGNAL = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 3'd0,
    ST_BLOCKED  = 3'd1,
    ST_RELEASED = 3'd2,
    ST_NO_SLOT  = 3'd3,
    ST_UNUSED   = 3'd4,
    ST_REFUSED  = 3'd5,
    ST_QFULL    = 3'd6
  } status_t;

endpackage

`default_nettype wire

>>> src/counting_semaphore_bank.sv
// Counting semaphore bank: slot table, wait queues and the command sequencer.
//
// A command word enters on the s_axis channel and one result word leaves on
// the m_axis channel for every command. The block works on one command at a
// time: s_axis_tready is high only while it is idle.
// Close, wait and signal pass through capture, the table read-modify-write
// and the result. A signal that wakes a waiter also passes a pop step, as the
// oldest task id is read from the wait-queue memory, whose read data is
// registered. Create walks the slot-used flags one per cycle with the scan
// counter, until it reaches the lowest free slot or the last slot.
// The wait queues live in one memory holding a ring of task ids per
// semaphore; each command does at most one write or one read of it.
// Reset frees every slot, clears the counts and queue pointers, and needs no
// clearing pass; the queue memory is not cleared.
// A result word is held on m_axis until it is taken; while the receiver
// stalls, no further command is accepted.
`default_nettype none

`include "counting_semaphore_bank_macros.svh"

module counting_semaphore_bank
  import csb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  // action[1:0], sem_index[5:2], initial_count[20:6], task_id[26:21], zeros above
  input  wire logic [DATA_W-1:0] s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  // status[2:0], created_index[7:3], wake_task[13:8], count_after[29:14], zeros above
  output logic [DATA_W-1:0]      m_axis_tdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC,
    S_POP,
    S_OUT
  } state_t;

  state_t state;

  // Semaphore table.
  logic [NUM_SEMS-1:0]              slot_used;
  logic signed [COUNT_W-1:0]        sem_count  [NUM_SEMS];
  logic [QPTR_W-1:0]                queue_head [NUM_SEMS];
  logic [QPTR_W-1:0]                queue_tail [NUM_SEMS];

  // Captured command.
  action_t                          action_q;
  logic [SEM_W-1:0]                 idx_q;
  logic [INIT_W-1:0]                init_q;
  logic [TASK_ID_BITS-1:0]          task_q;
  logic [SLOT_W-1:0]                scan_idx;

  // Result word.
  status_t                          res_status;
  logic [CREATED_W-1:0]             res_created;
  logic [WAKE_W-1:0]                res_wake;
  logic signed [COUNT_W-1:0]        res_count;

  // Wait-queue memory.
  logic [TASK_ID_BITS-1:0]          wq_mem [MEM_DEPTH];
  logic [TASK_ID_BITS-1:0]          wq_rdata;
  logic                             mem_we;
  logic                             mem_re;
  logic [MEM_AW-1:0]                mem_waddr;
  logic [MEM_AW-1:0]                mem_raddr;

  // Decode of the addressed slot and the shared count adder.
  logic [SLOT_W-1:0]                slot;
  logic                             slot_ok;
  logic signed [COUNT_W-1:0]        cur_count;
  logic signed [COUNT_W-1:0]        addend;
  logic signed [COUNT_W-1:0]        sum_count;
  logic                             wait_blocks;
  logic                             queue_full;
  logic                             at_max;
  logic                             wake_needed;
  logic [QPTR_W-1:0]                head_next;
  logic [QPTR_W-1:0]                tail_next;

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata  = {(DATA_W - STATUS_W - CREATED_W - WAKE_W - COUNT_W)'(0),
                          res_count, res_wake, res_created, res_status};

  always_comb begin
    slot        = idx_q[SLOT_W-1:0];
    slot_ok     = (32'(idx_q) < NUM_SEMS) && slot_used[slot];
    cur_count   = sem_count[slot];
    addend      = (action_q == ACT_SIGNAL) ? COUNT_W'(1) : COUNT_W'(-1);
    sum_count   = cur_count + addend;
    // Wait blocks when the decremented count would go below zero.
    wait_blocks = (cur_count <= COUNT_W'(0));
    queue_full  = (cur_count <= QFULL_COUNT);
    at_max      = (cur_count >= COUNT_MAX);
    wake_needed = (sum_count <= COUNT_W'(0));
    head_next   = (32'(queue_head[slot]) == QUEUE_DEPTH - 1) ? '0 : queue_head[slot] + 1'b1;
    tail_next   = (32'(queue_tail[slot]) == QUEUE_DEPTH - 1) ? '0 : queue_tail[slot] + 1'b1;
    mem_waddr   = {slot, queue_tail[slot]};
    mem_raddr   = {slot, queue_head[slot]};
    mem_we      = (state == S_EXEC) && slot_ok && (action_q == ACT_WAIT) &&
                  wait_blocks && !queue_full;
    mem_re      = (state == S_EXEC) && slot_ok && (action_q == ACT_SIGNAL) &&
                  !at_max && wake_needed;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      wq_mem[mem_waddr] <= task_q;
    end
    if (mem_re) begin
      wq_rdata <= wq_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      slot_used  <= '0;
      sem_count  <= '{default: '0};
      queue_head <= '{default: '0};
      queue_tail <= '{default: '0};
    end else begin
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            action_q <= action_t'(s_axis_tdata[1:0]);
            idx_q    <= s_axis_tdata[5:2];
            init_q   <= s_axis_tdata[20:6];
            task_q   <= TASK_ID_BITS'(s_axis_tdata[26:21]);
            scan_idx <= '0;
            state    <= (action_t'(s_axis_tdata[1:0]) == ACT_CREATE) ? S_SCAN : S_EXEC;
          end
        end
        S_SCAN: begin
          res_wake <= '0;
          if (!slot_used[scan_idx]) begin
            slot_used[scan_idx]  <= 1'b1;
            sem_count[scan_idx]  <= COUNT_W'(init_q);
            queue_head[scan_idx] <= '0;
            queue_tail[scan_idx] <= '0;
            res_status           <= ST_DONE;
            res_created          <= CREATED_W'(scan_idx);
            res_count            <= COUNT_W'(init_q);
            state                <= S_OUT;
          end else if (32'(scan_idx) == NUM_SEMS - 1) begin
            res_status  <= ST_NO_SLOT;
            res_created <= NO_SLOT;
            res_count   <= '0;
            state       <= S_OUT;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        S_EXEC: begin
          res_created <= NO_SLOT;
          res_wake    <= '0;
          state       <= S_OUT;
          if (!slot_ok) begin
            res_status <= ST_UNUSED;
            res_count  <= '0;
          end else begin
            case (action_q)
              ACT_CLOSE: begin
                if (cur_count < COUNT_W'(0)) begin
                  res_status <= ST_REFUSED;
                  res_count  <= cur_count;
                end else begin
                  slot_used[slot]  <= 1'b0;
                  sem_count[slot]  <= '0;
                  queue_head[slot] <= '0;
                  queue_tail[slot] <= '0;
                  res_status       <= ST_DONE;
                  res_count        <= '0;
                end
              end
              ACT_WAIT: begin
                if (wait_blocks && queue_full) begin
                  res_status <= ST_QFULL;
                  res_count  <= cur_count;
                end else begin
                  if (wait_blocks) begin
                    queue_tail[slot] <= tail_next;
                  end
                  sem_count[slot] <= sum_count;
                  res_status      <= wait_blocks ? ST_BLOCKED : ST_DONE;
                  res_count       <= sum_count;
                end
              end
              ACT_SIGNAL: begin
                if (at_max) begin
                  res_status <= ST_DONE;
                  res_count  <= cur_count;
                end else begin
                  sem_count[slot] <= sum_count;
                  res_count       <= sum_count;
                  if (wake_needed) begin
                    // The oldest waiter arrives from the memory next cycle.
                    queue_head[slot] <= head_next;
                    res_status       <= ST_RELEASED;
                    state            <= S_POP;
                  end else begin
                    res_status <= ST_DONE;
                  end
                end
              end
              default: begin
                res_status <= ST_UNUSED;
                res_count  <= '0;
              end
            endcase
          end
        end
        S_POP: begin
          res_wake <= WAKE_W'(wq_rdata);
          state    <= S_OUT;
        end
        S_OUT: begin
          if (m_axis_tready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `CSB_ASSERT_ALWAYS(a_one_word_in_flight, !(s_axis_tready && m_axis_tvalid))
  `CSB_ASSERT_IMPLY(a_created_slot_used, m_axis_tvalid && res_created != NO_SLOT, slot_used[res_created[SLOT_W-1:0]])
  `CSB_ASSERT_IMPLY(a_blocked_count_negative, m_axis_tvalid && res_status == ST_BLOCKED, res_count < COUNT_W'(0))
  `CSB_ASSERT_IMPLY(a_released_count_nonpos, m_axis_tvalid && res_status == ST_RELEASED, res_count <= COUNT_W'(0))
  `CSB_ASSERT_NEXT(a_pop_after_read, mem_re, state == S_POP)

endmodule

`default_nettype wire
